FILE: hdl/ctidm_pkg.sv
package ctidm_pkg;

   localparam int MaxHeldBytes = 5;
   localparam int QueueDepth   = 4;

   // widest bundle: a full held sequence plus the closing byte
   localparam int SlotCount = 6;
   localparam int CntWidth  = 3;

   localparam logic [7:0] LeadMin   = 8'hC0;
   localparam logic [7:0] LeadMax   = 8'hFD;
   localparam logic [7:0] FlushByte = 8'hFE;
   localparam logic [7:0] EscByte   = 8'hFF;
   localparam logic [7:0] ZeroByte  = 8'h00;
   localparam logic [7:0] SymMask   = 8'h3F;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_IMAGE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   out_kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [CntWidth-1:0]       count;
      logic [SlotCount-1:0][7:0] bytes;
      logic [SlotCount-1:0][1:0] kinds;
   } bundle_type;

   // bytes held (lead included) before the final byte completes
   function automatic logic [CntWidth-1:0] seq_need(input logic [7:0] lead);
      logic [CntWidth-1:0] need;
      if ((lead & 8'hE0) == 8'hC0) begin
         need = 3'd1;
      end else if ((lead & 8'hF0) == 8'hE0) begin
         need = 3'd2;
      end else if ((lead & 8'hF8) == 8'hF0) begin
         need = 3'd3;
      end else if ((lead & 8'hFC) == 8'hF8) begin
         need = 3'd4;
      end else begin
         need = 3'd5;
      end
      return need;
   endfunction

endpackage

FILE: hdl/ctidm_front.sv
module ctidm_front #(
   parameter int MAX_HELD_BYTES = ctidm_pkg::MaxHeldBytes
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ctidm_pkg::req_type    req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output ctidm_pkg::bundle_type q_data
);

   localparam int HCW = $clog2(MAX_HELD_BYTES + 1);
   localparam int HIW = $clog2(MAX_HELD_BYTES);

   typedef enum logic [3:0] {
      MODE_TEXT    = 4'b0001,
      MODE_SEQ     = 4'b0010,
      MODE_ESC     = 4'b0100,
      MODE_SWALLOW = 4'b1000
   } mode_type;

   mode_type   mode_ff, mode_in, eff_mode;
   logic [7:0] held_ff [MAX_HELD_BYTES];
   logic [7:0] held0_in;
   logic       held0_we, heldn_we;
   logic [HCW-1:0] hcnt_ff, hcnt_in;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  scnt_ff, scnt_in;

   logic [7:0]  b;
   logic        accept;
   logic [5:0]  sym;
   logic [23:0] word24;
   logic [ctidm_pkg::CntWidth-1:0] need;
   ctidm_pkg::bundle_type bundle;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_data.in_byte;
   assign sym       = 6'(b & ctidm_pkg::SymMask);
   assign word24    = {sym, acc_ff};
   assign need      = ctidm_pkg::seq_need(held_ff[0]);

   always_comb begin
      eff_mode = mode_ff;
      if (mode_ff == MODE_SEQ && b[7:6] != 2'b10) begin
         eff_mode = MODE_TEXT;
      end
      if (mode_ff == MODE_ESC && b != ctidm_pkg::ZeroByte) begin
         eff_mode = MODE_TEXT;
      end

      mode_in  = eff_mode;
      hcnt_in  = hcnt_ff;
      acc_in   = acc_ff;
      scnt_in  = scnt_ff;
      held0_we = 1'b0;
      heldn_we = 1'b0;
      held0_in = b;
      bundle   = '0;

      case (eff_mode)
         MODE_TEXT: begin
            if (b >= ctidm_pkg::LeadMin && b <= ctidm_pkg::LeadMax) begin
               held0_we = 1'b1;
               hcnt_in  = HCW'(1);
               mode_in  = MODE_SEQ;
            end else if (b == ctidm_pkg::EscByte) begin
               mode_in = MODE_ESC;
            end else if (b[7:6] == 2'b10) begin
               case (scnt_ff)
                  2'd0: begin
                     acc_in[5:0] = sym;
                     scnt_in     = 2'd1;
                  end
                  2'd1: begin
                     acc_in[11:6] = sym;
                     scnt_in      = 2'd2;
                  end
                  2'd2: begin
                     acc_in[17:12] = sym;
                     scnt_in       = 2'd3;
                  end
                  default: begin
                     bundle.count    = 3'd3;
                     bundle.bytes[0] = word24[7:0];
                     bundle.bytes[1] = word24[15:8];
                     bundle.bytes[2] = word24[23:16];
                     bundle.kinds[0] = ctidm_pkg::KIND_IMAGE;
                     bundle.kinds[1] = ctidm_pkg::KIND_IMAGE;
                     bundle.kinds[2] = ctidm_pkg::KIND_IMAGE;
                     acc_in          = '0;
                     scnt_in         = 2'd0;
                  end
               endcase
            end else if (b == ctidm_pkg::FlushByte) begin
               case (scnt_ff)
                  2'd3: begin
                     bundle.count    = 3'd3;
                     bundle.bytes[0] = acc_ff[7:0];
                     bundle.bytes[1] = acc_ff[15:8];
                     bundle.kinds[0] = ctidm_pkg::KIND_IMAGE;
                     bundle.kinds[1] = ctidm_pkg::KIND_IMAGE;
                     bundle.kinds[2] = ctidm_pkg::KIND_END;
                  end
                  2'd2: begin
                     bundle.count    = 3'd2;
                     bundle.bytes[0] = acc_ff[7:0];
                     bundle.kinds[0] = ctidm_pkg::KIND_IMAGE;
                     bundle.kinds[1] = ctidm_pkg::KIND_END;
                  end
                  default: begin
                     bundle.count    = 3'd1;
                     bundle.kinds[0] = ctidm_pkg::KIND_END;
                  end
               endcase
               acc_in  = '0;
               scnt_in = 2'd0;
            end else begin
               bundle.count    = 3'd1;
               bundle.bytes[0] = b;
               bundle.kinds[0] = ctidm_pkg::KIND_TEXT;
            end
         end
         MODE_SEQ: begin
            if (need <= ctidm_pkg::CntWidth'(MAX_HELD_BYTES)
                && ctidm_pkg::CntWidth'(hcnt_ff) == need) begin
               bundle.count = ctidm_pkg::CntWidth'(hcnt_ff) + 3'd1;
               for (int i = 0; i < MAX_HELD_BYTES; i++) begin
                  bundle.bytes[i] = (HCW'(i) < hcnt_ff) ? held_ff[i] : b;
               end
               bundle.bytes[MAX_HELD_BYTES] = b;
               for (int i = 0; i < ctidm_pkg::SlotCount; i++) begin
                  bundle.kinds[i] = ctidm_pkg::KIND_TEXT;
               end
               mode_in = MODE_TEXT;
            end else if (hcnt_ff < HCW'(MAX_HELD_BYTES)) begin
               heldn_we = 1'b1;
               hcnt_in  = hcnt_ff + HCW'(1);
            end
         end
         MODE_ESC: begin
            mode_in = MODE_SWALLOW;
         end
         default: begin
            mode_in = MODE_TEXT;
         end
      endcase

      if (req_data.end_of_chunk) begin
         mode_in = MODE_TEXT;
         hcnt_in = '0;
         acc_in  = '0;
         scnt_in = 2'd0;
      end
   end

   assign q_push = accept && bundle.count != '0;
   assign q_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         hcnt_ff <= '0;
         acc_ff  <= '0;
         scnt_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hcnt_ff <= hcnt_in;
         acc_ff  <= acc_in;
         scnt_ff <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held0_we) begin
         held_ff[0] <= held0_in;
      end
      if (accept && heldn_we) begin
         held_ff[hcnt_ff[HIW-1:0]] <= b;
      end
   end

   a_seq_has_lead: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SEQ) |-> (hcnt_ff != '0))
      else $error("sequence mode with no held lead byte");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (scnt_ff == 2'd0) |-> (acc_ff == '0))
      else $error("symbol accumulator not clear with empty group");

   a_chunk_reset: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_chunk) |=>
         (mode_ff == MODE_TEXT && hcnt_ff == '0 && scnt_ff == 2'd0))
      else $error("state not cleared after end of chunk");

endmodule

FILE: hdl/ctidm_queue.sv
module ctidm_queue #(
   parameter int DEPTH = ctidm_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ctidm_pkg::bundle_type push_data,
   input  logic                  pop,
   output ctidm_pkg::bundle_type head_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ctidm_pkg::bundle_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign empty     = count_ff == '0;
   assign full      = count_ff == CW'(DEPTH);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

FILE: hdl/ctidm_back.sv
module ctidm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ctidm_pkg::bundle_type head_data,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ctidm_pkg::rsp_type    rsp_data
);

   ctidm_pkg::bundle_type bundle_ff;
   logic                  busy_ff, busy_in;
   logic [ctidm_pkg::CntWidth-1:0] idx_ff, idx_in;
   logic fire, is_last, done, load;

   assign is_last = idx_ff == bundle_ff.count - 3'd1;
   assign fire    = busy_ff && !rsp_stall;
   assign done    = fire && is_last;
   assign load    = !empty && (!busy_ff || done);
   assign pop     = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= head_data;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_data.out_byte = bundle_ff.bytes[idx_ff];
   assign rsp_data.out_kind = ctidm_pkg::kind_type'(bundle_ff.kinds[idx_ff]);
   assign rsp_data.last     = is_last;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bundle_ff.count != '0 && idx_ff < bundle_ff.count))
      else $error("word index outside bundle");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bundle_ff.kinds[idx_ff] != 2'd3))
      else $error("unused kind code in bundle");

endmodule

FILE: hdl/console_text_and_image_demux.sv
// channel   dir   valid       stall       payload
// req       in    req_valid   req_stall   req_data  (in_byte, end_of_chunk)
// rsp       out   rsp_valid   rsp_stall   rsp_data  (out_byte, out_kind, last)
//
// one input word per cycle unless req_stall; each yields zero to six output words,
// one per cycle unless rsp_stall; words pass the queue entry, then the back register
// a four-entry queue between front and back absorbs bursts; req_stall is queue full
// output words are limited to one per cycle by the back serializer
// synchronous active-high reset returns to text mode with empty queue and groups
module console_text_and_image_demux #(
   parameter int MAX_HELD_BYTES = ctidm_pkg::MaxHeldBytes,
   parameter int QUEUE_DEPTH    = ctidm_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ctidm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ctidm_pkg::rsp_type rsp_data
);

   ctidm_pkg::bundle_type push_data, head_data;
   logic push, pop, empty, full;

   ctidm_front #(
      .MAX_HELD_BYTES(MAX_HELD_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (full),
      .q_push   (push),
      .q_data   (push_data)
   );

   ctidm_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .empty    (empty),
      .full     (full)
   );

   ctidm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_data(head_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

FILE: tb/console_text_and_image_demux_tb.sv
module console_text_and_image_demux_tb;

   typedef enum logic [1:0] {
      SCAN_TEXT    = 2'd0,
      SCAN_SEQ     = 2'd1,
      SCAN_ESC     = 2'd2,
      SCAN_SWALLOW = 2'd3
   } scan_mode_type;

   localparam int HoldCycles  = 200;
   localparam int RandomWords = 100;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   ctidm_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   ctidm_pkg::rsp_type rsp_data;

   // predictor state
   scan_mode_type scan_mode = SCAN_TEXT;
   logic [7:0]    held [ctidm_pkg::MaxHeldBytes];
   int            held_cnt  = 0;
   logic [17:0]   sym_acc   = '0;
   int            sym_cnt   = 0;

   ctidm_pkg::rsp_type expected_words [$];
   int      mismatches  = 0;
   int      sent_words  = 0;
   bit      idle_enable = 1'b1;
   bit      hold_req    = 1'b0;
   int      stall_left  = 0;
   int      run_left    = 0;

   console_text_and_image_demux u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // continuation bytes a lead byte waits for: leading ones minus one, capped at MaxHeldBytes
   function automatic int lead_span(input logic [7:0] lead);
      int ones;
      ones = 0;
      while (ones < 8 && lead[7 - ones]) begin
         ones++;
      end
      return (ones - 1 > ctidm_pkg::MaxHeldBytes) ? ctidm_pkg::MaxHeldBytes : ones - 1;
   endfunction

   function automatic ctidm_pkg::rsp_type make_word(input logic [7:0] b,
                                                    input ctidm_pkg::kind_type k);
      ctidm_pkg::rsp_type w;
      w.out_byte = b;
      w.out_kind = k;
      w.last     = 1'b0;
      return w;
   endfunction

   task automatic clear_scan_state();
      scan_mode = SCAN_TEXT;
      held_cnt  = 0;
      sym_acc   = '0;
      sym_cnt   = 0;
   endtask

   task automatic predict_word(input logic [7:0] b, input logic eoc);
      ctidm_pkg::rsp_type outs [$];
      ctidm_pkg::rsp_type w;
      logic [23:0]        x;
      int                 need;
      if (scan_mode == SCAN_SEQ && b[7:6] != 2'b10) scan_mode = SCAN_TEXT;
      if (scan_mode == SCAN_ESC && b != ctidm_pkg::ZeroByte) scan_mode = SCAN_TEXT;
      case (scan_mode)
         SCAN_TEXT: begin
            if (b >= ctidm_pkg::LeadMin && b <= ctidm_pkg::LeadMax) begin
               held[0]   = b;
               held_cnt  = 1;
               scan_mode = SCAN_SEQ;
            end else if (b == ctidm_pkg::EscByte) begin
               scan_mode = SCAN_ESC;
            end else if (b[7:6] == 2'b10) begin
               if (sym_cnt == 3) begin
                  x = {b[5:0], sym_acc};
                  outs.push_back(make_word(x[7:0], ctidm_pkg::KIND_IMAGE));
                  outs.push_back(make_word(x[15:8], ctidm_pkg::KIND_IMAGE));
                  outs.push_back(make_word(x[23:16], ctidm_pkg::KIND_IMAGE));
                  sym_acc = '0;
                  sym_cnt = 0;
               end else begin
                  sym_acc = sym_acc | (18'(b[5:0]) << (6 * sym_cnt));
                  sym_cnt++;
               end
            end else if (b == ctidm_pkg::FlushByte) begin
               if (sym_cnt == 3) begin
                  outs.push_back(make_word(sym_acc[7:0], ctidm_pkg::KIND_IMAGE));
                  outs.push_back(make_word(sym_acc[15:8], ctidm_pkg::KIND_IMAGE));
               end else if (sym_cnt == 2) begin
                  outs.push_back(make_word(sym_acc[7:0], ctidm_pkg::KIND_IMAGE));
               end
               outs.push_back(make_word(ctidm_pkg::ZeroByte, ctidm_pkg::KIND_END));
               sym_acc = '0;
               sym_cnt = 0;
            end else begin
               outs.push_back(make_word(b, ctidm_pkg::KIND_TEXT));
            end
         end
         SCAN_SEQ: begin
            need = lead_span(held[0]);
            if (held_cnt == need) begin
               for (int i = 0; i < need; i++) begin
                  outs.push_back(make_word(held[i], ctidm_pkg::KIND_TEXT));
               end
               outs.push_back(make_word(b, ctidm_pkg::KIND_TEXT));
               scan_mode = SCAN_TEXT;
            end else if (held_cnt < ctidm_pkg::MaxHeldBytes) begin
               held[held_cnt] = b;
               held_cnt++;
            end
         end
         SCAN_ESC: begin
            scan_mode = SCAN_SWALLOW;
         end
         default: begin
            scan_mode = SCAN_TEXT;
         end
      endcase
      foreach (outs[i]) begin
         w      = outs[i];
         w.last = (i == outs.size() - 1);
         expected_words.push_back(w);
      end
      if (eoc) clear_scan_state();
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic send_word(input logic [7:0] b, input logic eoc = 1'b0);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_chunk: eoc};
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_word(b, eoc);
      sent_words++;
      gap = idle_enable ? gap_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic rand_eoc();
      return $urandom_range(0, 39) == 0;
   endfunction

   function automatic logic [7:0] rand_cont();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic send_utf8(input bit broken);
      logic [7:0] lead;
      int         span;
      int         k;
      case ($urandom_range(0, 4))
         0:       lead = 8'hC0 | 8'($urandom_range(0, 31));
         1:       lead = 8'hE0 | 8'($urandom_range(0, 15));
         2:       lead = 8'hF0 | 8'($urandom_range(0, 7));
         3:       lead = 8'hF8 | 8'($urandom_range(0, 3));
         default: lead = 8'hFC | 8'($urandom_range(0, 1));
      endcase
      span = lead_span(lead);
      k    = broken ? $urandom_range(0, span - 1) : span;
      send_word(lead, rand_eoc());
      repeat (k) send_word(rand_cont(), rand_eoc());
      if (broken) begin
         send_word($urandom_range(0, 1) ? 8'($urandom_range(0, 127)) :
                   8'($urandom_range(192, 255)), rand_eoc());
      end
   endtask

   task automatic send_segment();
      case ($urandom_range(0, 9))
         0, 1: begin
            repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 127)), rand_eoc());
         end
         2, 3: begin
            repeat ($urandom_range(1, 12)) send_word(rand_cont(), rand_eoc());
            if ($urandom_range(0, 1)) send_word(ctidm_pkg::FlushByte, rand_eoc());
         end
         4, 5: send_utf8(1'b0);
         6:    send_utf8(1'b1);
         7: begin
            send_word(ctidm_pkg::EscByte, rand_eoc());
            if ($urandom_range(0, 2) != 0) begin
               send_word(ctidm_pkg::ZeroByte, rand_eoc());
               send_word(8'($urandom), rand_eoc());
            end else begin
               send_word(8'($urandom_range(1, 255)), rand_eoc());
            end
         end
         8: begin
            repeat ($urandom_range(0, 3)) send_word(rand_cont(), rand_eoc());
            send_word(ctidm_pkg::FlushByte, rand_eoc());
         end
         default: begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom), rand_eoc());
         end
      endcase
   endtask

   task automatic test_directed();
      send_word(8'h00);
      send_word(8'h7F);
      // full group of four symbols
      send_word(8'h80);
      send_word(8'hBF);
      send_word(8'h95);
      send_word(8'hAA);
      // flush with three, then two symbols
      send_word(8'hBF);
      send_word(8'h80);
      send_word(8'hBF);
      send_word(ctidm_pkg::FlushByte);
      send_word(8'h81);
      send_word(8'h82);
      send_word(ctidm_pkg::FlushByte);
      // longest sequence
      send_word(ctidm_pkg::LeadMax);
      repeat (5) send_word(8'hBF);
      // broken sequence
      send_word(8'hE0);
      send_word(8'h41);
      // escape then zero swallows a byte
      send_word(ctidm_pkg::EscByte);
      send_word(ctidm_pkg::ZeroByte);
      send_word(8'h58);
      // partial group dropped at end of chunk
      send_word(8'h85, 1'b1);
      send_word(ctidm_pkg::FlushByte);
      drain_pause();
   endtask

   task automatic test_random();
      int stop_at;
      stop_at = sent_words + RandomWords;
      while (sent_words < stop_at) begin
         if ($urandom_range(0, 7) == 0) idle_enable = $urandom_range(0, 3) != 0;
         send_segment();
      end
      idle_enable = 1'b1;
      drain_pause();
   endtask

   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (4) begin
         send_word(ctidm_pkg::LeadMax);
         repeat (5) send_word(rand_cont());
         repeat (4) send_word(rand_cont());
      end
      drain_pause();
   endtask

   // receiver side stall
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req   = 1'b0;
         stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!idle_enable) begin
         rsp_stall <= 1'b0;
      end else if (run_left > 0) begin
         rsp_stall <= 1'b0;
         run_left--;
      end else begin
         stall_left = gap_len();
         run_left   = $urandom_range(0, 12);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin : check_words
      ctidm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_data));
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %h want %h", rsp_data.out_byte,
                                         want.out_byte));
            if (rsp_data.out_kind !== want.out_kind)
               report_mismatch($sformatf("out_kind %0d want %0d", rsp_data.out_kind,
                                         want.out_kind));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %b want %b", rsp_data.last, want.last));
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      test_random();
      repeat (16) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      if (mismatches == 0) begin
         $display("PASS console_text_and_image_demux");
      end else begin
         $display("FAIL console_text_and_image_demux");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL console_text_and_image_demux");
      $finish;
   end

endmodule
